### hw/rtl/xml_character_lexer_fsm_defines.svh
// Assertion macros for the XML character lexer.
`ifndef XML_CHARACTER_LEXER_FSM_DEFINES_SVH
`define XML_CHARACTER_LEXER_FSM_DEFINES_SVH

// Antecedent true in a cycle implies consequent true in the following cycle.
`define XCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Condition holds at every clock edge outside reset.
`define XCL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond)) else $error(msg);

`endif

### hw/rtl/xcl_pkg.sv
`timescale 1ns / 1ps

package xcl_pkg;

    typedef enum logic [4:0] {
        ST_START          = 5'd0,
        ST_ELEM           = 5'd1,
        ST_ELEM_EMPTY     = 5'd2,
        ST_ELEM_END       = 5'd3,
        ST_CLOSE          = 5'd4,
        ST_CLOSE_NAME     = 5'd5,
        ST_CLOSE_SPACE    = 5'd6,
        ST_ELEM_NAME      = 5'd7,
        ST_ELEM_SPACE     = 5'd8,
        ST_ATTR_NAME      = 5'd9,
        ST_ATTR_EXPECT    = 5'd10,
        ST_ATTR_ASSIGN    = 5'd11,
        ST_SQ_START       = 5'd12,
        ST_SQ             = 5'd13,
        ST_SQ_ENT_START   = 5'd14,
        ST_SQ_ENT         = 5'd15,
        ST_SQ_END         = 5'd16,
        ST_DQ_START       = 5'd17,
        ST_DQ             = 5'd18,
        ST_DQ_ENT_START   = 5'd19,
        ST_DQ_ENT         = 5'd20,
        ST_DQ_END         = 5'd21,
        ST_TEXT           = 5'd22,
        ST_TEXT_ENT_START = 5'd23,
        ST_TEXT_ENT       = 5'd24,
        ST_BAD            = 5'd25,
        ST_DONE           = 5'd26
    } t_lex_state;

    typedef enum logic [4:0] {
        CL_END,
        CL_NSTART,
        CL_NAME,
        CL_SPACE,
        CL_TEXT,
        CL_LT,
        CL_GT,
        CL_APOS,
        CL_QUOT,
        CL_AMP,
        CL_HASH,
        CL_EQ,
        CL_SEMI,
        CL_BANG,
        CL_DASH,
        CL_PCT,
        CL_SLASH,
        CL_QMARK
    } t_char_class;

    localparam int CODE_W = 21;

endpackage

### hw/rtl/xml_character_lexer_fsm.sv
// XML character lexer.
// Input channel (i_valid / o_ready) takes one request per character: a 21-bit
// code point and an end marker (end marker set, or code point zero, ends input).
// Output channel (o_valid / i_ready) returns one result per request: the new
// lexer state, an error flag (unexpected character) and a done flag (end of
// document). Both states are sticky until reset.
// The input register takes an accepted request, then the result register, which
// also holds the lexer state, loads the result and raises o_valid.
// Throughput: one request per cycle while the receiver does not stall; the class
// decode and next-state table sit between the two registers and close the state loop.
// Reset (synchronous, active low) empties both registers and returns the
// lexer to the start state.
// When the receiver stalls, the result holds and one more request can wait in
// the input register; o_ready drops once both are full.
`timescale 1ns / 1ps
`include "xml_character_lexer_fsm_defines.svh"

module xml_character_lexer_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [20:0] i_code_point,
    input  logic        i_end_marker,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_lexer_state,
    output logic        o_error_flag,
    output logic        o_done_flag
);
    import xcl_pkg::*;

    logic              r_in_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_end;
    logic              r_out_valid;
    t_lex_state        r_state;
    logic              r_error;
    logic              r_done;

    t_char_class       w_class;
    t_lex_state        n_state;
    logic              w_adv;

    // advance the input request whenever the result slot is free or being taken
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || !r_out_valid || i_ready;

    xcl_classify u_classify (
        .i_code_point (r_code),
        .i_end_marker (r_end),
        .o_class      (w_class)
    );

    xcl_next_state u_next_state (
        .i_state (r_state),
        .i_class (w_class),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_code <= i_code_point;
            r_end  <= i_end_marker;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= ST_START;
            r_error     <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_error     <= (n_state == ST_BAD);
                r_done      <= (n_state == ST_DONE);
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_lexer_state = r_state;
    assign o_error_flag  = r_error;
    assign o_done_flag   = r_done;

    `XCL_ASSERT_NEXT(a_bad_sticky, r_state == ST_BAD, r_state == ST_BAD, "unexpected state left")
    `XCL_ASSERT_NEXT(a_done_sticky, r_state == ST_DONE, r_state == ST_DONE, "done state left")
    `XCL_ASSERT_NEXT(a_state_hold, !w_adv, $stable(r_state), "state moved without a request")
    `XCL_ASSERT_ALWAYS(a_flags_match,
        (r_error == (r_state == ST_BAD)) && (r_done == (r_state == ST_DONE)),
        "flags disagree with state")

endmodule

### hw/rtl/xcl_classify.sv
`timescale 1ns / 1ps

module xcl_classify (
    input  logic [20:0]          i_code_point,
    input  logic                 i_end_marker,
    output xcl_pkg::t_char_class o_class
);
    import xcl_pkg::*;

    logic [CODE_W-1:0] w_c;
    logic              w_nstart;
    logic              w_name;
    logic              w_space;

    assign w_c = i_code_point;

    function automatic logic in_rng(input logic [CODE_W-1:0] c,
                                    input logic [CODE_W-1:0] lo,
                                    input logic [CODE_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    assign w_nstart = (w_c == 21'h3A) || (w_c == 21'h5F)
        || in_rng(w_c, 21'h41, 21'h5A) || in_rng(w_c, 21'h61, 21'h7A)
        || in_rng(w_c, 21'hC0, 21'hD6) || in_rng(w_c, 21'hD8, 21'hF6)
        || in_rng(w_c, 21'hF8, 21'h2FF) || in_rng(w_c, 21'h370, 21'h37D)
        || in_rng(w_c, 21'h37F, 21'h1FFF) || in_rng(w_c, 21'h200C, 21'h200D)
        || in_rng(w_c, 21'h2070, 21'h218F) || in_rng(w_c, 21'h2C00, 21'h2FEF)
        || in_rng(w_c, 21'h3001, 21'hD7FF) || in_rng(w_c, 21'hF900, 21'hFDCF)
        || in_rng(w_c, 21'hFDF0, 21'hFFFD) || in_rng(w_c, 21'h10000, 21'hEFFFF);

    assign w_name = (w_c == 21'h2E) || in_rng(w_c, 21'h30, 21'h39)
        || (w_c == 21'hB7) || in_rng(w_c, 21'h300, 21'h36F)
        || in_rng(w_c, 21'h203F, 21'h2040);

    assign w_space = (w_c == 21'h20) || (w_c == 21'h09)
        || (w_c == 21'h0D) || (w_c == 21'h0A);

    always_comb begin
        if (i_end_marker) begin
            o_class = CL_END;
        end else begin
            case (w_c)
                21'h3C:  o_class = CL_LT;
                21'h3E:  o_class = CL_GT;
                21'h27:  o_class = CL_APOS;
                21'h22:  o_class = CL_QUOT;
                21'h26:  o_class = CL_AMP;
                21'h23:  o_class = CL_HASH;
                21'h3D:  o_class = CL_EQ;
                21'h3B:  o_class = CL_SEMI;
                21'h21:  o_class = CL_BANG;
                21'h2D:  o_class = CL_DASH;
                21'h25:  o_class = CL_PCT;
                21'h2F:  o_class = CL_SLASH;
                21'h3F:  o_class = CL_QMARK;
                default: begin
                    if (w_nstart) begin
                        o_class = CL_NSTART;
                    end else if (w_name) begin
                        o_class = CL_NAME;
                    end else if (w_space) begin
                        o_class = CL_SPACE;
                    end else if (w_c == '0) begin
                        o_class = CL_END;
                    end else begin
                        o_class = CL_TEXT;
                    end
                end
            endcase
        end
    end

endmodule

### hw/rtl/xcl_next_state.sv
`timescale 1ns / 1ps

module xcl_next_state (
    input  xcl_pkg::t_lex_state  i_state,
    input  xcl_pkg::t_char_class i_class,
    output xcl_pkg::t_lex_state  o_state
);
    import xcl_pkg::*;

    function automatic t_lex_state ent_first(input t_char_class k, input t_lex_state nxt);
        return (k == CL_NSTART || k == CL_HASH) ? nxt : ST_BAD;
    endfunction

    function automatic t_lex_state ent_more(input t_char_class k, input t_lex_state self,
                                            input t_lex_state back);
        t_lex_state r;
        if (k == CL_NSTART || k == CL_NAME) begin
            r = self;
        end else if (k == CL_SEMI) begin
            r = back;
        end else begin
            r = ST_BAD;
        end
        return r;
    endfunction

    function automatic t_lex_state quoted(input t_char_class k, input t_char_class q,
                                          input t_lex_state self, input t_lex_state endst,
                                          input t_lex_state ent);
        t_lex_state r;
        if (k == CL_LT || k == CL_END) begin
            r = ST_BAD;
        end else if (k == q) begin
            r = endst;
        end else if (k == CL_AMP || k == CL_PCT) begin
            r = ent;
        end else begin
            r = self;
        end
        return r;
    endfunction

    function automatic t_lex_state after_value(input t_char_class k);
        t_lex_state r;
        if (k == CL_GT) begin
            r = ST_ELEM_END;
        end else if (k == CL_SPACE) begin
            r = ST_ELEM_SPACE;
        end else if (k == CL_SLASH || k == CL_QMARK) begin
            r = ST_ELEM_EMPTY;
        end else begin
            r = ST_BAD;
        end
        return r;
    endfunction

    always_comb begin
        o_state = ST_BAD;
        case (i_state)
            ST_START: begin
                if (i_class == CL_LT) o_state = ST_ELEM;
                else if (i_class == CL_SPACE) o_state = ST_START;
            end
            ST_ELEM: begin
                if (i_class == CL_BANG || i_class == CL_QMARK || i_class == CL_NSTART)
                    o_state = ST_ELEM_NAME;
                else if (i_class == CL_SLASH) o_state = ST_CLOSE;
            end
            ST_ELEM_EMPTY: begin
                if (i_class == CL_GT) o_state = ST_ELEM_END;
            end
            ST_ELEM_END: begin
                if (i_class == CL_END) o_state = ST_DONE;
                else if (i_class == CL_LT) o_state = ST_ELEM;
                else if (i_class == CL_GT) o_state = ST_BAD;
                else if (i_class == CL_PCT || i_class == CL_AMP) o_state = ST_TEXT_ENT_START;
                else o_state = ST_TEXT;
            end
            ST_CLOSE: begin
                if (i_class == CL_NSTART) o_state = ST_CLOSE_NAME;
            end
            ST_CLOSE_NAME: begin
                if (i_class == CL_NSTART || i_class == CL_NAME) o_state = ST_CLOSE_NAME;
                else if (i_class == CL_SPACE) o_state = ST_CLOSE_SPACE;
                else if (i_class == CL_GT) o_state = ST_ELEM_END;
            end
            ST_CLOSE_SPACE: begin
                if (i_class == CL_SPACE) o_state = ST_CLOSE_SPACE;
                else if (i_class == CL_GT) o_state = ST_ELEM_END;
            end
            ST_ELEM_NAME: begin
                // dash continues an element name only
                if (i_class == CL_NSTART || i_class == CL_NAME || i_class == CL_DASH)
                    o_state = ST_ELEM_NAME;
                else o_state = after_value(i_class);
            end
            ST_ELEM_SPACE: begin
                if (i_class == CL_NSTART) o_state = ST_ATTR_NAME;
                else o_state = after_value(i_class);
            end
            ST_ATTR_NAME: begin
                if (i_class == CL_NSTART || i_class == CL_NAME) o_state = ST_ATTR_NAME;
                else if (i_class == CL_EQ) o_state = ST_ATTR_ASSIGN;
                else if (i_class == CL_SPACE) o_state = ST_ATTR_EXPECT;
            end
            ST_ATTR_EXPECT: begin
                if (i_class == CL_EQ) o_state = ST_ATTR_ASSIGN;
                else if (i_class == CL_SPACE) o_state = ST_ATTR_EXPECT;
            end
            ST_ATTR_ASSIGN: begin
                if (i_class == CL_SPACE) o_state = ST_ATTR_ASSIGN;
                else if (i_class == CL_APOS) o_state = ST_SQ_START;
                else if (i_class == CL_QUOT) o_state = ST_DQ_START;
            end
            ST_SQ_START, ST_SQ: begin
                o_state = quoted(i_class, CL_APOS, ST_SQ, ST_SQ_END, ST_SQ_ENT_START);
            end
            ST_SQ_ENT_START: o_state = ent_first(i_class, ST_SQ_ENT);
            ST_SQ_ENT:       o_state = ent_more(i_class, ST_SQ_ENT, ST_SQ);
            ST_SQ_END, ST_DQ_END: o_state = after_value(i_class);
            ST_DQ_START, ST_DQ: begin
                o_state = quoted(i_class, CL_QUOT, ST_DQ, ST_DQ_END, ST_DQ_ENT_START);
            end
            ST_DQ_ENT_START: o_state = ent_first(i_class, ST_DQ_ENT);
            ST_DQ_ENT:       o_state = ent_more(i_class, ST_DQ_ENT, ST_DQ);
            ST_TEXT: begin
                if (i_class == CL_LT) o_state = ST_ELEM;
                else if (i_class == CL_AMP || i_class == CL_PCT) o_state = ST_TEXT_ENT_START;
                else if (i_class == CL_END) o_state = ST_DONE;
                else if (i_class == CL_GT) o_state = ST_BAD;
                else o_state = ST_TEXT;
            end
            ST_TEXT_ENT_START: o_state = ent_first(i_class, ST_TEXT_ENT);
            ST_TEXT_ENT:       o_state = ent_more(i_class, ST_TEXT_ENT, ST_TEXT);
            ST_BAD:            o_state = ST_BAD;
            ST_DONE:           o_state = ST_DONE;
            default:           o_state = ST_BAD;
        endcase
    end

endmodule

### tb/sv/xml_character_lexer_fsm_tb.sv
`timescale 1ns / 1ps

module xml_character_lexer_fsm_tb;
    import xcl_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 1110;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [20:0] code_point;
        logic        end_marker;
        logic        pinned;
        t_lex_state  state;
    } t_char_row;

    typedef struct {
        t_lex_state state;
        logic       error_flag;
        logic       done_flag;
    } t_lex_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [20:0] i_code_point;
    logic        i_end_marker;
    logic        o_valid;
    logic        i_ready;
    logic [4:0]  o_lexer_state;
    logic        o_error_flag;
    logic        o_done_flag;

    logic        gaps_on;
    logic        pin_en;
    t_lex_state  pin_state;
    t_lex_state  walk_state;
    t_lex_state  predicted_state;
    t_lex_result awaited_results[$];
    t_char_row   directed_rows[$];
    int          mismatches = 0;

    xml_character_lexer_fsm uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_point  (i_code_point),
        .i_end_marker  (i_end_marker),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_lexer_state (o_lexer_state),
        .o_error_flag  (o_error_flag),
        .o_done_flag   (o_done_flag)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic in_span(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
        return c >= lo && c <= hi;
    endfunction

    function automatic t_char_class char_class(logic [20:0] c, logic em);
        if (em)
            return CL_END;
        case (c)
            "<":  return CL_LT;
            ">":  return CL_GT;
            "'":  return CL_APOS;
            "\"": return CL_QUOT;
            "&":  return CL_AMP;
            "#":  return CL_HASH;
            "=":  return CL_EQ;
            ";":  return CL_SEMI;
            "!":  return CL_BANG;
            "-":  return CL_DASH;
            "%":  return CL_PCT;
            "/":  return CL_SLASH;
            "?":  return CL_QMARK;
            default: ;
        endcase
        if (c == ":" || c == "_" || in_span(c, 21'("A"), 21'("Z"))
            || in_span(c, 21'("a"), 21'("z"))
            || in_span(c, 21'hC0, 21'hD6) || in_span(c, 21'hD8, 21'hF6)
            || in_span(c, 21'hF8, 21'h2FF) || in_span(c, 21'h370, 21'h37D)
            || in_span(c, 21'h37F, 21'h1FFF) || in_span(c, 21'h200C, 21'h200D)
            || in_span(c, 21'h2070, 21'h218F) || in_span(c, 21'h2C00, 21'h2FEF)
            || in_span(c, 21'h3001, 21'hD7FF) || in_span(c, 21'hF900, 21'hFDCF)
            || in_span(c, 21'hFDF0, 21'hFFFD) || in_span(c, 21'h10000, 21'hEFFFF))
            return CL_NSTART;
        if (c == "." || in_span(c, 21'("0"), 21'("9")) || c == 21'hB7
            || in_span(c, 21'h300, 21'h36F) || in_span(c, 21'h203F, 21'h2040))
            return CL_NAME;
        if (c == " " || c == 21'h09 || c == 21'h0D || c == 21'h0A)
            return CL_SPACE;
        if (c == '0)
            return CL_END;
        return CL_TEXT;
    endfunction

    function automatic t_lex_state entity_first(t_char_class k, t_lex_state nxt);
        return (k == CL_NSTART || k == CL_HASH) ? nxt : ST_BAD;
    endfunction

    function automatic t_lex_state entity_more(t_char_class k, t_lex_state self,
                                               t_lex_state back);
        if (k == CL_NSTART || k == CL_NAME)
            return self;
        return (k == CL_SEMI) ? back : ST_BAD;
    endfunction

    function automatic t_lex_state quoted_char(t_char_class k, t_char_class quote,
                                               t_lex_state self, t_lex_state closed,
                                               t_lex_state ent);
        if (k == CL_LT || k == CL_END)
            return ST_BAD;
        if (k == quote)
            return closed;
        if (k == CL_AMP || k == CL_PCT)
            return ent;
        return self;
    endfunction

    function automatic t_lex_state after_value(t_char_class k);
        if (k == CL_GT)
            return ST_ELEM_END;
        if (k == CL_SPACE)
            return ST_ELEM_SPACE;
        if (k == CL_SLASH || k == CL_QMARK)
            return ST_ELEM_EMPTY;
        return ST_BAD;
    endfunction

    function automatic t_lex_state next_lexer_state(t_lex_state s, t_char_class k);
        case (s)
            ST_START: begin
                if (k == CL_LT)
                    return ST_ELEM;
                return (k == CL_SPACE) ? ST_START : ST_BAD;
            end
            ST_ELEM: begin
                if (k == CL_BANG || k == CL_QMARK || k == CL_NSTART)
                    return ST_ELEM_NAME;
                return (k == CL_SLASH) ? ST_CLOSE : ST_BAD;
            end
            ST_ELEM_EMPTY: return (k == CL_GT) ? ST_ELEM_END : ST_BAD;
            ST_ELEM_END: begin
                if (k == CL_END)
                    return ST_DONE;
                if (k == CL_LT)
                    return ST_ELEM;
                if (k == CL_GT)
                    return ST_BAD;
                if (k == CL_PCT || k == CL_AMP)
                    return ST_TEXT_ENT_START;
                return ST_TEXT;
            end
            ST_CLOSE: return (k == CL_NSTART) ? ST_CLOSE_NAME : ST_BAD;
            ST_CLOSE_NAME: begin
                if (k == CL_NSTART || k == CL_NAME)
                    return ST_CLOSE_NAME;
                if (k == CL_SPACE)
                    return ST_CLOSE_SPACE;
                return (k == CL_GT) ? ST_ELEM_END : ST_BAD;
            end
            ST_CLOSE_SPACE: begin
                if (k == CL_SPACE)
                    return ST_CLOSE_SPACE;
                return (k == CL_GT) ? ST_ELEM_END : ST_BAD;
            end
            ST_ELEM_NAME: begin
                // dash continues an element name only
                if (k == CL_NSTART || k == CL_NAME || k == CL_DASH)
                    return ST_ELEM_NAME;
                return after_value(k);
            end
            ST_ELEM_SPACE: begin
                if (k == CL_NSTART)
                    return ST_ATTR_NAME;
                return after_value(k);
            end
            ST_ATTR_NAME: begin
                if (k == CL_NSTART || k == CL_NAME)
                    return ST_ATTR_NAME;
                if (k == CL_EQ)
                    return ST_ATTR_ASSIGN;
                return (k == CL_SPACE) ? ST_ATTR_EXPECT : ST_BAD;
            end
            ST_ATTR_EXPECT: begin
                if (k == CL_EQ)
                    return ST_ATTR_ASSIGN;
                return (k == CL_SPACE) ? ST_ATTR_EXPECT : ST_BAD;
            end
            ST_ATTR_ASSIGN: begin
                if (k == CL_SPACE)
                    return ST_ATTR_ASSIGN;
                if (k == CL_APOS)
                    return ST_SQ_START;
                return (k == CL_QUOT) ? ST_DQ_START : ST_BAD;
            end
            ST_SQ_START, ST_SQ:
                return quoted_char(k, CL_APOS, ST_SQ, ST_SQ_END, ST_SQ_ENT_START);
            ST_SQ_ENT_START: return entity_first(k, ST_SQ_ENT);
            ST_SQ_ENT: return entity_more(k, ST_SQ_ENT, ST_SQ);
            ST_SQ_END, ST_DQ_END: return after_value(k);
            ST_DQ_START, ST_DQ:
                return quoted_char(k, CL_QUOT, ST_DQ, ST_DQ_END, ST_DQ_ENT_START);
            ST_DQ_ENT_START: return entity_first(k, ST_DQ_ENT);
            ST_DQ_ENT: return entity_more(k, ST_DQ_ENT, ST_DQ);
            ST_TEXT: begin
                if (k == CL_LT)
                    return ST_ELEM;
                if (k == CL_AMP || k == CL_PCT)
                    return ST_TEXT_ENT_START;
                if (k == CL_END)
                    return ST_DONE;
                return (k == CL_GT) ? ST_BAD : ST_TEXT;
            end
            ST_TEXT_ENT_START: return entity_first(k, ST_TEXT_ENT);
            ST_TEXT_ENT: return entity_more(k, ST_TEXT_ENT, ST_TEXT);
            ST_BAD: return ST_BAD;
            ST_DONE: return ST_DONE;
            default: return ST_BAD;
        endcase
    endfunction

    // Draw a code point from a mix of punctuation, name, space, class-edge and wide values.
    function automatic logic [20:0] pick_char();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            case ($urandom_range(0, 12))
                0: return 21'("<");
                1: return 21'(">");
                2: return 21'("'");
                3: return 21'("\"");
                4: return 21'("&");
                5: return 21'("#");
                6: return 21'("=");
                7: return 21'(";");
                8: return 21'("!");
                9: return 21'("-");
                10: return 21'("%");
                11: return 21'("/");
                default: return 21'("?");
            endcase
        end else if (sel < 50) begin
            case ($urandom_range(0, 15))
                0: return 21'(":");
                1: return 21'("_");
                2: return 21'($urandom_range("A", "Z"));
                3: return 21'($urandom_range("a", "z"));
                4: return 21'($urandom_range(21'hC0, 21'hD6));
                5: return 21'($urandom_range(21'hD8, 21'hF6));
                6: return 21'($urandom_range(21'hF8, 21'h2FF));
                7: return 21'($urandom_range(21'h370, 21'h37D));
                8: return 21'($urandom_range(21'h37F, 21'h1FFF));
                9: return 21'($urandom_range(21'h200C, 21'h200D));
                10: return 21'($urandom_range(21'h2070, 21'h218F));
                11: return 21'($urandom_range(21'h2C00, 21'h2FEF));
                12: return 21'($urandom_range(21'h3001, 21'hD7FF));
                13: return 21'($urandom_range(21'hF900, 21'hFDCF));
                14: return 21'($urandom_range(21'hFDF0, 21'hFFFD));
                default: return 21'($urandom_range(21'h10000, 21'hEFFFF));
            endcase
        end else if (sel < 60) begin
            case ($urandom_range(0, 4))
                0: return 21'(".");
                1: return 21'($urandom_range("0", "9"));
                2: return 21'hB7;
                3: return 21'($urandom_range(21'h300, 21'h36F));
                default: return 21'($urandom_range(21'h203F, 21'h2040));
            endcase
        end else if (sel < 72) begin
            case ($urandom_range(0, 3))
                0: return 21'(" ");
                1: return 21'h09;
                2: return 21'h0D;
                default: return 21'h0A;
            endcase
        end else if (sel < 82) begin
            // values right next to the class ranges
            case ($urandom_range(0, 19))
                0: return 21'hD7;
                1: return 21'hF7;
                2: return 21'h37E;
                3: return 21'h2000;
                4: return 21'h200B;
                5: return 21'h200E;
                6: return 21'h206F;
                7: return 21'h2190;
                8: return 21'h2BFF;
                9: return 21'h2FF0;
                10: return 21'h3000;
                11: return 21'hD800;
                12: return 21'hFDD0;
                13: return 21'hFFFE;
                14: return 21'hF0000;
                15: return 21'hB6;
                16: return 21'h203E;
                17: return 21'h2041;
                18: return 21'h10FFFF;
                default: return 21'($urandom_range(21'h40, 21'h40) | (1 << $urandom_range(0, 2)));
            endcase
        end else if (sel < 91) begin
            return 21'($urandom_range(1, 127));
        end
        return 21'($urandom_range(0, 21'h1FFFFF));
    endfunction

    // Keep the document alive: reject anything that would end or break it.
    function automatic logic [20:0] walk_char(t_lex_state s);
        logic [20:0] c;
        t_lex_state  nxt;
        do begin
            c = pick_char();
            nxt = next_lexer_state(s, char_class(c, 1'b0));
        end while (nxt == ST_BAD || nxt == ST_DONE);
        return c;
    endfunction

    function automatic void add_row(logic [20:0] cp, logic em, logic pinned, t_lex_state st);
        t_char_row row;
        row.code_point = cp;
        row.end_marker = em;
        row.pinned = pinned;
        row.state = st;
        directed_rows.push_back(row);
    endfunction

    task automatic send_char(logic [20:0] cp, logic em, logic pinned, t_lex_state st);
        while (gaps_on && $urandom_range(0, 99) < 24) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_code_point <= cp;
        i_end_marker <= em;
        pin_en <= pinned;
        pin_state <= st;
        walk_state = next_lexer_state(walk_state, char_class(cp, em));
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_ready <= !gaps_on || ($urandom_range(0, 99) >= 24);
    end

    always @(posedge i_clk) begin : lexer_monitor
        t_lex_result want;
        if (!i_rst_n) begin
            predicted_state = ST_START;
        end else begin
            if (i_valid && o_ready) begin
                predicted_state = next_lexer_state(predicted_state,
                                                   char_class(i_code_point, i_end_marker));
                want.state = pin_en ? pin_state : predicted_state;
                want.error_flag = (want.state == ST_BAD);
                want.done_flag = (want.state == ST_DONE);
                awaited_results.push_back(want);
            end
            if (o_valid && i_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request pending: lexer_state=%0d", o_lexer_state);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_lexer_state !== want.state) begin
                        $error("lexer_state: expected %0d, got %0d", want.state, o_lexer_state);
                        mismatches++;
                    end
                    if (o_error_flag !== want.error_flag) begin
                        $error("error_flag: expected %0b, got %0b", want.error_flag,
                               o_error_flag);
                        mismatches++;
                    end
                    if (o_done_flag !== want.done_flag) begin
                        $error("done_flag: expected %0b, got %0b", want.done_flag,
                               o_done_flag);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int          n;
        int          tail_kind;
        logic [20:0] cp;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_code_point = '0;
        i_end_marker = 1'b0;
        pin_en = 1'b0;
        pin_state = ST_START;
        gaps_on = 1'b1;
        walk_state = ST_START;

        // one pass through tag, attribute, quoted value, entities, text and close tag
        add_row(21'h09,      1'b0, 1'b1, ST_START);
        add_row(21'("<"),    1'b0, 1'b1, ST_ELEM);
        add_row(21'("?"),    1'b0, 1'b0, ST_START);
        add_row(21'hEFFFF,   1'b0, 1'b1, ST_ELEM_NAME);
        add_row(21'("-"),    1'b0, 1'b0, ST_START);
        add_row(21'h0A,      1'b0, 1'b0, ST_START);
        add_row(21'h10000,   1'b0, 1'b0, ST_START);
        add_row(21'h2040,    1'b0, 1'b0, ST_START);
        add_row(21'h0D,      1'b0, 1'b0, ST_START);
        add_row(21'("="),    1'b0, 1'b0, ST_START);
        add_row(21'("\""),   1'b0, 1'b0, ST_START);
        add_row(21'h1FFFFF,  1'b0, 1'b1, ST_DQ);
        add_row(21'("%"),    1'b0, 1'b0, ST_START);
        add_row(21'("#"),    1'b0, 1'b0, ST_START);
        add_row(21'h36F,     1'b0, 1'b0, ST_START);
        add_row(21'(";"),    1'b0, 1'b0, ST_START);
        add_row(21'("\""),   1'b0, 1'b0, ST_START);
        add_row(21'(">"),    1'b0, 1'b0, ST_START);
        add_row(21'h110000,  1'b0, 1'b1, ST_TEXT);
        add_row(21'("&"),    1'b0, 1'b0, ST_START);
        add_row(21'("_"),    1'b0, 1'b0, ST_START);
        add_row(21'(";"),    1'b0, 1'b0, ST_START);
        add_row(21'("<"),    1'b0, 1'b0, ST_START);
        add_row(21'("/"),    1'b0, 1'b0, ST_START);
        add_row(21'("z"),    1'b0, 1'b0, ST_START);
        add_row(21'(" "),    1'b0, 1'b0, ST_START);
        add_row(21'(">"),    1'b0, 1'b1, ST_ELEM_END);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_char(directed_rows[i].code_point, directed_rows[i].end_marker,
                      directed_rows[i].pinned, directed_rows[i].state);

        // hold the sender until every directed result is back
        i_valid <= 1'b0;
        wait (awaited_results.size() == 0);
        @(negedge i_clk);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            gaps_on = !(n >= 300 && n < 500);
            if (n == 700) begin
                i_valid <= 1'b0;
                wait (awaited_results.size() == 0);
                @(negedge i_clk);
            end
            send_char(walk_char(walk_state), 1'b0, 1'b0, ST_START);
        end

        // finish the document or break it, then show the terminal state holds
        gaps_on = 1'b1;
        tail_kind = $urandom_range(0, 2);
        if (tail_kind == 2) begin
            do cp = pick_char();
            while (next_lexer_state(walk_state, char_class(cp, 1'b0)) != ST_BAD);
            send_char(cp, 1'b0, 1'b1, ST_BAD);
        end else begin
            while (walk_state != ST_ELEM_END && walk_state != ST_TEXT)
                send_char(walk_char(walk_state), 1'b0, 1'b0, ST_START);
            if (tail_kind == 0)
                send_char(21'($urandom_range(0, 21'h1FFFFF)), 1'b1, 1'b1, ST_DONE);
            else
                send_char('0, 1'b0, 1'b1, ST_DONE);
        end
        send_char(21'h1FFFFF, 1'b1, 1'b0, ST_START);
        send_char(21'("<"), 1'b0, 1'b0, ST_START);
        send_char('0, 1'b0, 1'b0, ST_START);
        send_char(21'(" "), 1'b0, 1'b0, ST_START);
        send_char(21'(">"), 1'b0, 1'b0, ST_START);
        repeat (4) send_char(pick_char(), 1'(($urandom_range(0, 1))), 1'b0, ST_START);

        i_valid <= 1'b0;
        wait (awaited_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/xcl_pkg.sv
hw/rtl/xcl_classify.sv
hw/rtl/xcl_next_state.sv
hw/rtl/xml_character_lexer_fsm.sv
tb/sv/xml_character_lexer_fsm_tb.sv
